FILE: hdl/spsm_pkg.sv
package spsm_pkg;

   localparam int unsigned ElemBits = 256;
   localparam int unsigned WordBits = 64;
   localparam int unsigned DegBits  = 10;
   localparam int unsigned CsrIdxBits = 2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_MAC   = 2'd1,
      OP_READ  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_MOD_W0 = 2'd0,
      CSR_MOD_W1 = 2'd1,
      CSR_MOD_W2 = 2'd2,
      CSR_MOD_W3 = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_MUL,
      ST_MULACC,
      ST_RED,
      ST_ADD,
      ST_SUB,
      ST_WB,
      ST_OUT
   } state_type;

endpackage

FILE: hdl/sparse_poly_scalar_mac_modp_unit.sv
// Load and write finish on acceptance; a read registers the memory entry, then the
// result, and holds until the result is taken; a multiply-accumulate runs 64 passes
// of a 32x32 multiplier, then a one-bit-per-cycle reduction of the 512-bit product
// (skipped with a zero modulus), then an add, a conditional subtract and a writeback.
// Throughput: one transaction at a time; next accepted after the current one ends.
// Reset: synchronous, active high; clears control, modulus and scalar, then sweeps
// the accumulator memory to zero while no request is taken.
module sparse_poly_scalar_mac_modp_unit #(
   parameter int unsigned ACC_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [9:0]  req_degree,
   input  logic [63:0] req_data_w0,
   input  logic [63:0] req_data_w1,
   input  logic [63:0] req_data_w2,
   input  logic [63:0] req_data_w3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_read_degree,
   output logic [63:0] rsp_sum_w0,
   output logic [63:0] rsp_sum_w1,
   output logic [63:0] rsp_sum_w2,
   output logic [63:0] rsp_sum_w3,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int unsigned AddrBits = (ACC_ENTRIES > 1) ? $clog2(ACC_ENTRIES) : 1;
   localparam int unsigned CntBits  = $clog2(ACC_ENTRIES + 1);

   spsm_pkg::state_type state_ff, state_in;

   logic [255:0] modulus_ff;
   logic [255:0] scalar_ff;
   logic [255:0] mem [ACC_ENTRIES];
   logic [255:0] rdata_ff;

   logic [CntBits-1:0]  clr_ff, clr_in;
   logic [255:0]        coef_ff, coef_in;
   logic [AddrBits-1:0] addr_ff, addr_in;
   logic [9:0]          deg_ff, deg_in;
   logic                inrange_ff, inrange_in;
   logic [511:0]        prod_ff, prod_in;
   logic [63:0]         pp_ff, pp_in;
   logic [3:0]          psh_ff, psh_in;
   logic [5:0]          pidx_ff, pidx_in;
   logic                ppv_ff, ppv_in;
   logic [256:0]        rem_ff, rem_in;
   logic [8:0]          bit_ff, bit_in;
   logic [256:0]        sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [9:0]          rsp_deg_ff, rsp_deg_in;
   logic [255:0]        rsp_sum_ff, rsp_sum_in;

   logic        accept;
   logic        wr_en;
   logic [AddrBits-1:0] wr_addr;
   logic [255:0] wr_data;
   logic        deg_ok;
   logic [255:0] req_data;
   logic        mod_zero;
   logic [31:0] mul_a, mul_b;
   logic [256:0] shifted;
   logic [256:0] mod_ext;

   assign req_data = {req_data_w3, req_data_w2, req_data_w1, req_data_w0};
   assign deg_ok   = 32'(req_degree) < ACC_ENTRIES;
   assign accept   = req_valid && !req_stall;
   assign mod_zero = (modulus_ff == '0);
   assign mod_ext  = {1'b0, modulus_ff};

   // Partial product operands picked by the pass counter: 32-bit limbs.
   assign mul_a   = coef_ff[{pidx_ff[2:0], 5'd0} +: 32];
   assign mul_b   = scalar_ff[{pidx_ff[5:3], 5'd0} +: 32];
   assign shifted = {rem_ff[255:0], prod_ff[bit_ff]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spsm_pkg::ST_CLEAR: begin
            if (clr_ff == CntBits'(ACC_ENTRIES - 1)) state_in = spsm_pkg::ST_IDLE;
         end
         spsm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (spsm_pkg::op_type'(req_operation))
                  spsm_pkg::OP_LOAD:  state_in = spsm_pkg::ST_IDLE;
                  spsm_pkg::OP_WRITE: state_in = spsm_pkg::ST_IDLE;
                  spsm_pkg::OP_READ:  state_in = spsm_pkg::ST_RD;
                  spsm_pkg::OP_MAC:   state_in = deg_ok ? spsm_pkg::ST_MUL : spsm_pkg::ST_IDLE;
                  default:            state_in = spsm_pkg::ST_IDLE;
               endcase
            end
         end
         spsm_pkg::ST_RD:     state_in = spsm_pkg::ST_OUT;
         spsm_pkg::ST_OUT:    if (!rsp_valid_ff) state_in = spsm_pkg::ST_IDLE;
         spsm_pkg::ST_MUL:    state_in = spsm_pkg::ST_MULACC;
         spsm_pkg::ST_MULACC: begin
            if (pidx_ff == 6'd0 && !ppv_ff)
               state_in = mod_zero ? spsm_pkg::ST_ADD : spsm_pkg::ST_RED;
            else
               state_in = spsm_pkg::ST_MULACC;
         end
         spsm_pkg::ST_RED:    if (bit_ff == 9'd0) state_in = spsm_pkg::ST_ADD;
         spsm_pkg::ST_ADD:    state_in = spsm_pkg::ST_SUB;
         spsm_pkg::ST_SUB:    state_in = spsm_pkg::ST_WB;
         spsm_pkg::ST_WB:     state_in = spsm_pkg::ST_IDLE;
         default:             state_in = spsm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_stall    = (state_ff != spsm_pkg::ST_IDLE);
      clr_in       = clr_ff;
      coef_in      = coef_ff;
      addr_in      = addr_ff;
      deg_in       = deg_ff;
      inrange_in   = inrange_ff;
      prod_in      = prod_ff;
      pp_in        = pp_ff;
      psh_in       = psh_ff;
      pidx_in      = pidx_ff;
      ppv_in       = ppv_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_deg_in   = rsp_deg_ff;
      rsp_sum_in   = rsp_sum_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      unique case (state_ff)
         spsm_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AddrBits-1:0];
            clr_in  = clr_ff + 1'b1;
         end
         spsm_pkg::ST_IDLE: begin
            if (accept) begin
               coef_in    = req_data;
               addr_in    = AddrBits'(req_degree);
               deg_in     = req_degree;
               inrange_in = deg_ok;
               prod_in    = '0;
               pidx_in    = 6'd0;
               ppv_in     = 1'b0;
               if (req_operation == spsm_pkg::OP_WRITE && deg_ok) begin
                  wr_en   = 1'b1;
                  wr_addr = AddrBits'(req_degree);
                  wr_data = req_data;
               end
            end
         end
         spsm_pkg::ST_RD: begin
            // Memory data valid this cycle; the output register is free here.
            rsp_valid_in = 1'b1;
            rsp_deg_in   = deg_ff;
            rsp_sum_in   = inrange_ff ? rdata_ff : '0;
         end
         spsm_pkg::ST_MUL: begin
            pp_in   = mul_a * mul_b;
            psh_in  = {1'b0, pidx_ff[2:0]} + {1'b0, pidx_ff[5:3]};
            ppv_in  = 1'b1;
            pidx_in = pidx_ff + 1'b1;
         end
         spsm_pkg::ST_MULACC: begin
            // Add the previous partial product at its limb position, start the next one.
            if (ppv_ff) begin
               prod_in = prod_ff + ({448'd0, pp_ff} << {psh_ff, 5'd0});
            end
            if (pidx_ff != 6'd0) begin
               pp_in   = mul_a * mul_b;
               psh_in  = {1'b0, pidx_ff[2:0]} + {1'b0, pidx_ff[5:3]};
               ppv_in  = 1'b1;
               pidx_in = pidx_ff + 1'b1;
            end else begin
               ppv_in = 1'b0;
            end
            rem_in = '0;
            bit_in = 9'd511;
         end
         spsm_pkg::ST_RED: begin
            rem_in = (shifted >= mod_ext) ? shifted - mod_ext : shifted;
            bit_in = bit_ff - 1'b1;
         end
         spsm_pkg::ST_ADD: begin
            sum_in = {1'b0, rdata_ff}
                   + (mod_zero ? {1'b0, prod_ff[255:0]} : rem_ff);
         end
         spsm_pkg::ST_SUB: begin
            if (sum_ff >= mod_ext) sum_in = sum_ff - mod_ext;
         end
         spsm_pkg::ST_WB: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = sum_ff[255:0];
         end
         spsm_pkg::ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // Accumulator memory: one write port, one registered read port at the next address.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spsm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         modulus_ff   <= '0;
         scalar_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && req_operation == spsm_pkg::OP_LOAD) scalar_ff <= req_data;
         if (csr_write) begin
            unique case (spsm_pkg::csr_idx_type'(csr_index))
               spsm_pkg::CSR_MOD_W0: modulus_ff[63:0]    <= csr_data;
               spsm_pkg::CSR_MOD_W1: modulus_ff[127:64]  <= csr_data;
               spsm_pkg::CSR_MOD_W2: modulus_ff[191:128] <= csr_data;
               spsm_pkg::CSR_MOD_W3: modulus_ff[255:192] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      coef_ff    <= coef_in;
      addr_ff    <= addr_in;
      deg_ff     <= deg_in;
      inrange_ff <= inrange_in;
      prod_ff    <= prod_in;
      pp_ff      <= pp_in;
      psh_ff     <= psh_in;
      pidx_ff    <= pidx_in;
      ppv_ff     <= ppv_in;
      rem_ff     <= rem_in;
      bit_ff     <= bit_in;
      sum_ff     <= sum_in;
      rsp_deg_ff <= rsp_deg_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_degree = rsp_deg_ff;
   assign rsp_sum_w0      = rsp_sum_ff[63:0];
   assign rsp_sum_w1      = rsp_sum_ff[127:64];
   assign rsp_sum_w2      = rsp_sum_ff[191:128];
   assign rsp_sum_w3      = rsp_sum_ff[255:192];

endmodule

FILE: tb/sv/spsm_checker.sv
module spsm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [9:0]  req_degree,
   input  logic [63:0] req_data_w0,
   input  logic [63:0] req_data_w1,
   input  logic [63:0] req_data_w2,
   input  logic [63:0] req_data_w3,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [9:0]  rsp_read_degree,
   input  logic [63:0] rsp_sum_w0,
   input  logic [63:0] rsp_sum_w1,
   input  logic [63:0] rsp_sum_w2,
   input  logic [63:0] rsp_sum_w3,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          reads_pending
);

   typedef struct {
      logic [9:0]   degree;
      logic [255:0] value;
   } entry_read_type;

   logic [255:0]   modulus;
   logic [255:0]   scalar;
   logic [255:0]   acc_mem [1024];
   entry_read_type read_queue [$];

   // Residue product of two 256-bit operands; a zero modulus means modulo 2^256.
   function automatic logic [255:0] residue_product(logic [255:0] a, logic [255:0] b,
                                                    logic [255:0] m);
      logic [511:0] full;
      logic [511:0] rem;
      full = {256'd0, a} * {256'd0, b};
      if (m == '0) return full[255:0];
      rem = full % {256'd0, m};
      return rem[255:0];
   endfunction

   // Single conditional subtraction after a 257-bit add.
   function automatic logic [255:0] residue_sum(logic [255:0] a, logic [255:0] b,
                                                logic [255:0] m);
      logic [256:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[255:0];
   endfunction

   always @(posedge clock) begin
      entry_read_type exp_rd;
      logic [255:0]   data;
      if (reset) begin
         modulus = '0;
         scalar = '0;
         for (int i = 0; i < 1024; i++) acc_mem[i] = '0;
         read_queue.delete();
         fail_count = 0;
      end else begin
         // Register writes track the modulus.
         if (csr_write) begin
            case (spsm_pkg::csr_idx_type'(csr_index))
               spsm_pkg::CSR_MOD_W0: modulus[63:0] = csr_data;
               spsm_pkg::CSR_MOD_W1: modulus[127:64] = csr_data;
               spsm_pkg::CSR_MOD_W2: modulus[191:128] = csr_data;
               spsm_pkg::CSR_MOD_W3: modulus[255:192] = csr_data;
               default: ;
            endcase
         end
         // Compare a returned entry against the oldest pending read.
         if (rsp_valid && !rsp_stall) begin
            if (read_queue.size() == 0) begin
               $error("unexpected result transaction, read_degree %0d", rsp_read_degree);
               fail_count++;
            end else begin
               exp_rd = read_queue.pop_front();
               if (rsp_read_degree !== exp_rd.degree) begin
                  $error("read_degree expected %0d actual %0d", exp_rd.degree,
                         rsp_read_degree);
                  fail_count++;
               end
               if (rsp_sum_w0 !== exp_rd.value[63:0]) begin
                  $error("sum_w0 expected %h actual %h", exp_rd.value[63:0], rsp_sum_w0);
                  fail_count++;
               end
               if (rsp_sum_w1 !== exp_rd.value[127:64]) begin
                  $error("sum_w1 expected %h actual %h", exp_rd.value[127:64], rsp_sum_w1);
                  fail_count++;
               end
               if (rsp_sum_w2 !== exp_rd.value[191:128]) begin
                  $error("sum_w2 expected %h actual %h", exp_rd.value[191:128],
                         rsp_sum_w2);
                  fail_count++;
               end
               if (rsp_sum_w3 !== exp_rd.value[255:192]) begin
                  $error("sum_w3 expected %h actual %h", exp_rd.value[255:192],
                         rsp_sum_w3);
                  fail_count++;
               end
            end
         end
         // Update the accumulator image for each accepted request transaction.
         if (req_valid && !req_stall) begin
            data = {req_data_w3, req_data_w2, req_data_w1, req_data_w0};
            case (spsm_pkg::op_type'(req_operation))
               spsm_pkg::OP_LOAD: scalar = data;
               spsm_pkg::OP_MAC: acc_mem[req_degree] = residue_sum(acc_mem[req_degree],
                  residue_product(data, scalar, modulus), modulus);
               spsm_pkg::OP_READ: begin
                  exp_rd.degree = req_degree;
                  exp_rd.value = acc_mem[req_degree];
                  read_queue.push_back(exp_rd);
               end
               spsm_pkg::OP_WRITE: acc_mem[req_degree] = data;
               default: ;
            endcase
         end
      end
      reads_pending = read_queue.size();
   end

endmodule

FILE: tb/sv/sparse_poly_scalar_mac_modp_unit_tb.sv
module sparse_poly_scalar_mac_modp_unit_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [9:0]  req_degree;
   logic [63:0] req_data_w0;
   logic [63:0] req_data_w1;
   logic [63:0] req_data_w2;
   logic [63:0] req_data_w3;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [9:0]  rsp_read_degree;
   logic [63:0] rsp_sum_w0;
   logic [63:0] rsp_sum_w1;
   logic [63:0] rsp_sum_w2;
   logic [63:0] rsp_sum_w3;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   int fail_count;
   int reads_pending;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_cycles;
   bit backlog_go;
   bit backlog_done;

   logic [255:0] modulus_now;
   logic [9:0]   hot_degrees [8];

   sparse_poly_scalar_mac_modp_unit dut (.*);

   spsm_checker checker_i (.*);

   // Clock with a 10-unit period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Result side stall, with one long hold-off to back the block up.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (backlog_go && !backlog_done) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            backlog_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= 20000) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [255:0] rand_word256();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
   endfunction

   // Mostly operands below the modulus, sometimes unrestricted ones.
   function automatic logic [255:0] rand_operand();
      logic [255:0] v;
      v = rand_word256();
      if (modulus_now != '0 && $urandom_range(3) != 0) v = v % modulus_now;
      return v;
   endfunction

   task automatic send_item(spsm_pkg::op_type op, logic [9:0] degree, logic [255:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_degree <= degree;
      {req_data_w3, req_data_w2, req_data_w1, req_data_w0} <= data;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Wait for the block to go idle, then load a new modulus.
   task automatic load_modulus(logic [255:0] m);
      req_valid <= 1'b0;
      wait (reads_pending == 0);
      repeat (700) @(posedge clock);
      for (int w = 0; w < 4; w++) begin
         csr_write <= 1'b1;
         csr_index <= spsm_pkg::csr_idx_type'(w);
         csr_data <= m[w*64 +: 64];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      modulus_now = m;
   endtask

   // One polynomial: a scalar load, its coefficients, with reads and writes mixed in.
   task automatic send_polynomial();
      logic [9:0] deg;
      send_item(spsm_pkg::OP_LOAD, 10'd0, rand_operand());
      repeat ($urandom_range(5, 1)) begin
         deg = ($urandom_range(3) == 0) ? 10'($urandom) : hot_degrees[$urandom_range(7)];
         case ($urandom_range(9))
            0: send_item(spsm_pkg::OP_READ, deg, rand_word256());
            1: send_item(spsm_pkg::OP_WRITE, deg, rand_operand());
            default: send_item(spsm_pkg::OP_MAC, deg, rand_operand());
         endcase
      end
      send_item(spsm_pkg::OP_READ, hot_degrees[$urandom_range(7)], rand_word256());
   endtask

   initial begin
      logic [255:0] moduli [4];
      moduli[0] = '0;
      moduli[1] = 256'hFFFF_FFFB;
      moduli[2] = {256{1'b1}} - 256'd188;
      moduli[3] = {256{1'b1}};
      for (int i = 0; i < 8; i++) hot_degrees[i] = 10'($urandom);
      hot_degrees[0] = 10'd0;
      hot_degrees[1] = 10'd1023;
      modulus_now = '0;
      send_idle_pct = 23;
      recv_idle_pct = 66;
      backlog_go = 1'b0;
      backlog_done = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= spsm_pkg::OP_LOAD;
      req_degree <= '0;
      {req_data_w3, req_data_w2, req_data_w1, req_data_w0} <= '0;
      csr_write <= 1'b0;
      csr_index <= spsm_pkg::CSR_MOD_W0;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes under a zero modulus, then entries not below p.
      send_item(spsm_pkg::OP_READ, 10'd0, '0);
      send_item(spsm_pkg::OP_WRITE, 10'd0, {256{1'b1}});
      send_item(spsm_pkg::OP_WRITE, 10'd1023, 256'h1);
      send_item(spsm_pkg::OP_READ, 10'd0, {256{1'b1}});
      send_item(spsm_pkg::OP_READ, 10'd1023, '0);
      send_item(spsm_pkg::OP_LOAD, 10'd0, {256{1'b1}});
      send_item(spsm_pkg::OP_MAC, 10'd1023, {256{1'b1}});
      send_item(spsm_pkg::OP_MAC, 10'd0, {256{1'b1}});
      send_item(spsm_pkg::OP_READ, 10'd1023, '0);
      send_item(spsm_pkg::OP_READ, 10'd0, '0);
      send_item(spsm_pkg::OP_LOAD, 10'd0, '0);
      send_item(spsm_pkg::OP_MAC, 10'd5, {256{1'b1}});
      send_item(spsm_pkg::OP_READ, 10'd5, '0);
      load_modulus(moduli[2]);
      send_item(spsm_pkg::OP_WRITE, 10'd7, {256{1'b1}});
      send_item(spsm_pkg::OP_LOAD, 10'd0, 256'h1);
      send_item(spsm_pkg::OP_MAC, 10'd7, '0);
      send_item(spsm_pkg::OP_READ, 10'd7, '0);
      send_item(spsm_pkg::OP_LOAD, 10'd0, {256{1'b1}});
      send_item(spsm_pkg::OP_MAC, 10'd8, {256{1'b1}});
      send_item(spsm_pkg::OP_READ, 10'd8, '0);

      // Random polynomials over each idling mode and each modulus.
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 66 : 0;
         recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 23 : 0;
         for (int p = 0; p < 4; p++) begin
            load_modulus(moduli[p]);
            repeat (6) send_polynomial();
         end
      end

      // Hold the result side while reads keep coming.
      backlog_go = 1'b1;
      repeat (6) begin
         send_item(spsm_pkg::OP_READ, hot_degrees[$urandom_range(7)], rand_word256());
      end
      req_valid <= 1'b0;

      wait (reads_pending == 0);
      repeat (700) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
